@@ hw/rtl/lkvc_pkg.sv @@
// Shared constants, codes and the lookup result type for the LRU key-value cache.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package lkvc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic [IDX_W-1:0] lru_idx;
  } lookup_t;

endpackage

@@ hw/rtl/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lkvc_pkg and instantiates lkvc_lookup.
//
// Usage:
//   A transaction is presented on command, key and value with start high; it
//   is taken at a clock edge where start is high and busy is low. busy is only
//   high while rst is asserted, so a transaction can be issued every cycle.
//   Each transaction is registered, looked up and applied in the following
//   cycle, and its result is registered in the result register and appears
//   on hit, read_value, evicted and evicted_key with done high for exactly
//   one cycle. Throughput is one transaction per cycle: the key compare
//   across all entries and the rank update sit in one stage between the
//   input register and the result register, and the next transaction sees
//   the updated state. The receiver cannot stall; results must be captured
//   when done is high. capacity must be written through cfg_write and
//   cfg_data only while no transaction is in flight; the block itself does
//   not enforce this. Zero is taken as one, values above the entry count as
//   the entry count. Synchronous reset empties the cache, drops any
//   transaction in flight and sets the capacity to the full entry count.
module lru_key_value_cache (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command,
  input  logic [lkvc_pkg::KEY_W-1:0] key,
  input  logic [lkvc_pkg::VAL_W-1:0] value,
  input  logic                       cfg_write,
  input  logic [5:0]                 cfg_data,
  output logic                       done,
  output logic                       hit,
  output logic [lkvc_pkg::VAL_W-1:0] read_value,
  output logic                       evicted,
  output logic [lkvc_pkg::KEY_W-1:0] evicted_key
);

  logic [lkvc_pkg::KEY_W-1:0]   entry_key [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0]   entry_value [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0] entry_valid;
  logic [lkvc_pkg::IDX_W-1:0]   rank [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   count;
  logic [lkvc_pkg::CNT_W-1:0]   capacity;

  logic                       s1_valid;
  logic                       s1_command;
  logic [lkvc_pkg::KEY_W-1:0] s1_key;
  logic [lkvc_pkg::VAL_W-1:0] s1_value;

  lkvc_pkg::lookup_t          lk;
  logic                       is_put;
  logic                       do_insert;
  logic                       do_evict;
  logic [lkvc_pkg::IDX_W-1:0] slot;
  logic [lkvc_pkg::CNT_W-1:0] capacity_next;

  assign busy = rst;

  // Clamp the capacity once, when it is written.
  always_comb begin
    if (cfg_data == 6'd0) begin
      capacity_next = lkvc_pkg::CNT_W'(1);
    end else if (lkvc_pkg::CNT_W'(cfg_data) > lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES)) begin
      capacity_next = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else begin
      capacity_next = lkvc_pkg::CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else if (cfg_write) begin
      capacity <= capacity_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_command <= command;
    s1_key     <= key;
    s1_value   <= value;
  end

  lkvc_lookup u_lookup (
    .entry_key   (entry_key),
    .entry_valid (entry_valid),
    .rank        (rank),
    .count       (count),
    .key         (s1_key),
    .result      (lk)
  );

  assign is_put    = (s1_command == lkvc_pkg::CMD_PUT);
  assign do_insert = s1_valid && !lk.hit && is_put;
  assign do_evict  = do_insert && (count >= capacity);

  // Entries are only ever freed by an eviction that refills the same slot, so
  // the valid entries always occupy the lowest indexes and the next free slot
  // is the current count.
  assign slot = do_evict ? lk.lru_idx : count[lkvc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      count       <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (s1_valid && lk.hit) begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (entry_valid[i] && rank[i] < lk.hit_rank) begin
          rank[i] <= lkvc_pkg::IDX_W'(rank[i] + 1'b1);
        end
      end
      rank[lk.hit_idx] <= '0;
    end else if (do_insert) begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (entry_valid[i] && lkvc_pkg::IDX_W'(i) != slot) begin
          rank[i] <= lkvc_pkg::IDX_W'(rank[i] + 1'b1);
        end
      end
      rank[slot]        <= '0;
      entry_valid[slot] <= 1'b1;
      if (!do_evict) begin
        count <= lkvc_pkg::CNT_W'(count + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && lk.hit && is_put) begin
      entry_value[lk.hit_idx] <= s1_value;
    end else if (do_insert) begin
      entry_key[slot]   <= s1_key;
      entry_value[slot] <= s1_value;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit         <= lk.hit;
    read_value  <= (lk.hit && !is_put) ? entry_value[lk.hit_idx] : '0;
    evicted     <= do_evict;
    evicted_key <= do_evict ? entry_key[lk.lru_idx] : '0;
  end

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("registered transaction produced no result");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !hit)
    else $error("eviction reported on a hit");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(count))
    else $error("valid entries disagree with entry count");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
    else $error("entry count above the number of entries");
`endif

endmodule

@@ hw/rtl/lkvc_lookup.sv @@
// Parallel key match and least-recent search over all cache entries.
// Depends on lkvc_pkg for sizes and the lookup_t result type.
module lkvc_lookup (
  input  logic [lkvc_pkg::KEY_W-1:0] entry_key [lkvc_pkg::ENTRIES],
  input  logic [lkvc_pkg::ENTRIES-1:0] entry_valid,
  input  logic [lkvc_pkg::IDX_W-1:0] rank [lkvc_pkg::ENTRIES],
  input  logic [lkvc_pkg::CNT_W-1:0] count,
  input  logic [lkvc_pkg::KEY_W-1:0] key,
  output lkvc_pkg::lookup_t          result
);

  logic [lkvc_pkg::IDX_W-1:0] oldest_rank;

  // Valid entries hold the distinct ranks 0 to count-1, so the least recent
  // one is the entry whose rank equals count-1.
  assign oldest_rank = lkvc_pkg::IDX_W'(count - lkvc_pkg::CNT_W'(1));

  always_comb begin
    result = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (entry_valid[i] && entry_key[i] == key) begin
        result.hit      = 1'b1;
        result.hit_idx  = result.hit_idx | lkvc_pkg::IDX_W'(i);
        result.hit_rank = result.hit_rank | rank[i];
      end
      if (entry_valid[i] && rank[i] == oldest_rank) begin
        result.lru_idx = result.lru_idx | lkvc_pkg::IDX_W'(i);
      end
    end
  end

endmodule

@@ verif/tb_lru_key_value_cache.sv @@
// Self-checking testbench for lru_key_value_cache: directed table, then randomised gets and puts.
// Depends on lkvc_pkg and the lru_key_value_cache RTL; results are checked against an LRU model or typed-in values.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  typedef struct packed {
    logic                       hit;
    logic [lkvc_pkg::VAL_W-1:0] rd;
    logic                       ev;
    logic [lkvc_pkg::KEY_W-1:0] evk;
  } access_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CAPACITY} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       cmd;
    logic [lkvc_pkg::KEY_W-1:0] k;
    logic [lkvc_pkg::VAL_W-1:0] v;
    logic [5:0]                 cap;
    logic                       fixed;
    access_result_t             want;
  } plan_row_t;

  localparam access_result_t ALL_ZERO = '0;
  localparam int PLAN_ROWS = 28;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 95;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       command;
  logic [lkvc_pkg::KEY_W-1:0] key;
  logic [lkvc_pkg::VAL_W-1:0] value;
  logic                       cfg_write;
  logic [5:0]                 cfg_data;
  logic                       done;
  logic                       hit;
  logic [lkvc_pkg::VAL_W-1:0] read_value;
  logic                       evicted;
  logic [lkvc_pkg::KEY_W-1:0] evicted_key;

  // Sideband held with each transaction: a typed-in expectation replaces the predicted one.
  logic           fixed_chk;
  access_result_t fixed_res;

  // Model of the cache contents and replacement order (rank 0 is most recent).
  logic [lkvc_pkg::KEY_W-1:0] slot_key  [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] slot_val  [lkvc_pkg::ENTRIES];
  bit                         slot_used [lkvc_pkg::ENTRIES];
  int                         slot_rank [lkvc_pkg::ENTRIES];
  int                         live_count;
  logic [5:0]                 model_cap;

  access_result_t expected_results[$];
  int mismatches;
  int accepted;
  int hits_seen;
  int evictions_seen;
  int settings_used;
  bit idle_ok;

  logic [lkvc_pkg::KEY_W-1:0] key_pool [64];
  int                         pool_n;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 6'd0,  1'b1, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000, 6'd0,  1'b1, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 6'd0,  1'b1,
      '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  1'b1, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0,  1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'hA5A5_5A5A, 6'd0,  1'b1,
      '{1'b1, 32'h0000_0000, 1'b0, 32'h0}},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0,  1'b1,
      '{1'b1, 32'hA5A5_5A5A, 1'b0, 32'h0}},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_1234, 32'h0000_0000, 6'd0,  1'b1, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0001, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0002, 32'h0000_0002, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_CAPACITY, lkvc_pkg::CMD_GET, 32'h0,         32'h0,         6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0003, 32'h0000_0003, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0004, 32'h0000_0004, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0003, 32'h0000_0000, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_CAPACITY, lkvc_pkg::CMD_GET, 32'h0,         32'h0,         6'd63, 1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0005, 32'h5555_5555, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_CAPACITY, lkvc_pkg::CMD_GET, 32'h0,         32'h0,         6'd2,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0006, 32'hAAAA_AAAA, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h0000_0007, 32'h0000_0007, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h0000_0002, 32'h0000_0000, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_CAPACITY, lkvc_pkg::CMD_GET, 32'h0,         32'h0,         6'd1,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h0000_0008, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h1234_5678, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0009, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_ACCESS,   lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 6'd0,  1'b0, ALL_ZERO},
    '{ROW_CAPACITY, lkvc_pkg::CMD_GET, 32'h0,         32'h0,         6'd32, 1'b0, ALL_ZERO}
  };

  lru_key_value_cache dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .value       (value),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .done        (done),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

  always #1 clk = ~clk;

  // Applies one get or put to the model and returns what the cache should report.
  function automatic access_result_t lru_access(logic cmd,
                                                logic [lkvc_pkg::KEY_W-1:0] k,
                                                logic [lkvc_pkg::VAL_W-1:0] v);
    access_result_t r;
    int found;
    int slot;
    int lim;
    int old_rank;
    r = '0;
    found = -1;
    slot = -1;
    lim = model_cap;
    if (lim < 1) lim = 1;
    if (lim > lkvc_pkg::ENTRIES) lim = lkvc_pkg::ENTRIES;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      old_rank = slot_rank[found];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
      end
      slot_rank[found] = 0;
      if (cmd == lkvc_pkg::CMD_PUT) slot_val[found] = v;
      else r.rd = slot_val[found];
    end else if (cmd == lkvc_pkg::CMD_PUT) begin
      // A lowered capacity never shrinks the cache at once; each insert evicts one instead.
      if (live_count + 1 > lim || live_count >= lkvc_pkg::ENTRIES) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (slot_used[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        end
        if (slot >= 0) begin
          r.ev = 1'b1;
          r.evk = slot_key[slot];
          slot_used[slot] = 1'b0;
          live_count--;
        end
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (slot < 0 && !slot_used[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        slot_used[slot] = 1'b1;
        slot_key[slot] = k;
        slot_val[slot] = v;
        slot_rank[slot] = 0;
        live_count++;
      end
    end
    return r;
  endfunction

  // Scoreboard: results retire in order; each accepted transaction is predicted at acceptance.
  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (!rst) begin
      if (done) begin
        got = '{hit, read_value, evicted, evicted_key};
        hits_seen += hit;
        evictions_seen += evicted;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: hit=%0b rd=%h ev=%0b evk=%h",
                     $realtime, hit, read_value, evicted, evicted_key);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.rd !== want.rd ||
              got.ev !== want.ev || got.evk !== want.evk) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp hit=%0b rd=%h ev=%0b evk=%h got hit=%0b rd=%h ev=%0b evk=%h",
                       $realtime, want.hit, want.rd, want.ev, want.evk,
                       got.hit, got.rd, got.ev, got.evk);
          end
        end
      end
      if (start && !busy) begin
        want = lru_access(command, key, value);
        expected_results.push_back(fixed_chk ? fixed_res : want);
        accepted++;
      end
    end
  end

  task automatic issue(input logic cmd, input logic [lkvc_pkg::KEY_W-1:0] k,
                       input logic [lkvc_pkg::VAL_W-1:0] v,
                       input logic chk, input access_result_t r);
    @(negedge clk);
    if (idle_ok && $urandom_range(0, 99) < 8) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    key = k;
    value = v;
    fixed_chk = chk;
    fixed_res = r;
    do @(posedge clk); while (busy);
  endtask

  // Stops issuing until every outstanding transaction has returned.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [5:0] cap);
    drain();
    cfg_write = 1'b1;
    cfg_data = cap;
    model_cap = cap;
    settings_used++;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  initial begin
    int caps [RANDOM_PHASES];
    int eff;
    int wait_cycles;
    logic [lkvc_pkg::KEY_W-1:0] k;
    caps = '{32, 1, 2, 0, 5, 63, 16, 33, 0};
    caps[RANDOM_PHASES-1] = $urandom_range(0, 63);
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    command = lkvc_pkg::CMD_GET;
    key = '0;
    value = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    fixed_chk = 1'b0;
    fixed_res = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    live_count = 0;
    model_cap = 6'd32;
    mismatches = 0;
    accepted = 0;
    hits_seen = 0;
    evictions_seen = 0;
    settings_used = 0;
    idle_ok = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAPACITY) write_capacity(plan[i].cap);
      else issue(plan[i].cmd, plan[i].k, plan[i].v, plan[i].fixed, plan[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_capacity(6'(caps[p]));
      eff = (caps[p] < 1) ? 1 : (caps[p] > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : caps[p];
      // The pool is a little larger than the capacity so that hits and evictions both occur.
      pool_n = eff + eff / 2 + 2;
      if (pool_n > 64) pool_n = 64;
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      key_pool[0] = (p % 2) ? {lkvc_pkg::KEY_W{1'b1}} : '0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_ok = !(p == 3 || p == 4);
        if ($urandom_range(0, 99) < 8) k = $urandom;
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        issue(($urandom_range(0, 99) < 55) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET, k,
              $urandom, 1'b0, ALL_ZERO);
      end
    end

    @(negedge clk);
    start = 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    repeat (4) @(negedge clk);

    $display("Ran %0d transactions across %0d capacity settings, including zero and above range.",
             accepted, settings_used);
    $display("Saw %0d hits and %0d evictions; %0d mismatches.",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("FAIL lru_key_value_cache");
    $finish;
  end

endmodule
